### design/rfa_pkg.sv
// Shared types and constants for the reference-counted frame allocator.
package rfa_pkg;

  localparam int CMD_W     = 3;
  localparam int FRAME_W   = 10;
  localparam int PC_W      = 8;
  localparam int FO_W      = 10;
  localparam int ST_W      = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] FIRST_RST = 11'd0;
  localparam logic [CFG_W-1:0] LIMIT_RST = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_ADDREF = 3'd3,
    CMD_COW    = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADCOUNT = 2'd2,
    ST_RANGE    = 2'd3
  } st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST = 1'b0,
    REG_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP,
    S_INIT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    CW_DEC,
    CW_INC,
    CW_ZERO,
    CW_ONE_HEAD,
    CW_SWEEP
  } cnt_sel_t;

  typedef enum logic [1:0] {
    FO_NONE,
    FO_FRAME,
    FO_HEAD
  } fo_sel_t;

  typedef struct packed {
    logic     rd_en;
    logic     sweep_step;
    logic     sweep_init;
    logic     cnt_we;
    cnt_sel_t cnt_sel;
    logic     push;
    logic     pop;
    logic     head_init;
    logic     res_we;
    st_t      res_st;
    fo_sel_t  res_fo;
    logic     res_cp;
    logic     out_load;
  } rfa_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             range_bad;
    logic             cnt_zero;
    logic             cnt_one;
    logic             cnt_max;
    logic             head_null;
    logic             pc_one;
    logic             sweep_last;
    logic             out_free;
  } rfa_stat_t;

endpackage

### design/rfa_chan_if.sv
// Valid/ready channel interfaces for the command and result streams.
interface rfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [rfa_pkg::CMD_W-1:0]   cmd;
  logic [rfa_pkg::FRAME_W-1:0] frame;
  logic [rfa_pkg::PC_W-1:0]    page_count;

  modport source (output valid, output cmd, output frame, output page_count, input ready);
  modport sink (input valid, input cmd, input frame, input page_count, output ready);
endinterface

interface rfa_out_if;
  logic                     valid;
  logic                     ready;
  logic [rfa_pkg::FO_W-1:0] frame_out;
  logic [rfa_pkg::ST_W-1:0] status;
  logic                     copy_needed;

  modport source (output valid, output frame_out, output status, output copy_needed,
                  input ready);
  modport sink (input valid, input frame_out, input status, input copy_needed,
                output ready);
endinterface

### design/refcounted_frame_allocator_top.sv
// Top level of the reference-counted page frame allocator.
//
// Commands arrive on in_ch (cmd, frame, page_count) and each produces exactly one
// transfer on out_ch (frame_out, status, copy_needed). Both channels use valid/ready.
// The configuration port writes first_free_frame (index 0) and free_limit_frame
// (index 1) whenever cfg_we is high; write them only while no command is in flight.
//
// Each command does one read-modify-write of the count and link memories, which
// have one write and one registered read port each. A copy_on_write that drops a
// shared reference writes the count memory a second time, in S_POP, to pop a new
// frame. Init walks every frame once.
// The next command is taken as soon as the previous result has moved into the
// output register, so a waiting result does not block the next command; only when
// a second result completes while the first is still stalled does the block wait.
//
// After reset the block clears all reference counts, one frame per cycle, with
// in_ch.ready low; the free list is empty until init.
module refcounted_frame_allocator_top #(
  parameter int FRAMES   = 1024,
  parameter int REF_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rfa_in_if.sink                        in_ch,
  rfa_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rfa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rfa_pkg::CFG_W-1:0]     cfg_wdata
);
  import rfa_pkg::*;

  logic [CFG_W-1:0] first_r;
  logic [CFG_W-1:0] limit_r;
  rfa_ctrl_t        ctrl;
  rfa_stat_t        stat;
  logic             in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= FIRST_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_FIRST: first_r <= cfg_wdata;
        REG_LIMIT: limit_r <= cfg_wdata;
        default:   first_r <= first_r;
      endcase
    end
  end

  rfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rfa_dpath #(
    .FRAMES   (FRAMES),
    .REF_BITS (REF_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_ch.cmd),
    .in_frame        (in_ch.frame),
    .in_page_count   (in_ch.page_count),
    .cfg_first       (first_r),
    .cfg_limit       (limit_r),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_frame_out   (out_ch.frame_out),
    .out_status      (out_ch.status),
    .out_copy_needed (out_ch.copy_needed)
  );

  assign in_ch.ready = in_ready;

  // One command at a time: a transfer in closes the input until its result has moved into the output register.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a command is in flight");

  // The count clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("input open during the reset clearing pass");

  // A pop never takes the head of an empty list.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !stat.head_null)
    else $error("pop from an empty free list");

  // Only a frame losing its last reference goes back onto the list.
  a_push_last_ref: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> (stat.cnt_one && !stat.range_bad))
    else $error("frame pushed while still referenced");

endmodule

### design/rfa_ctrl.sv
// Controller state machine that sequences each allocator command.
module rfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfa_pkg::rfa_stat_t stat,
  output rfa_pkg::rfa_ctrl_t ctrl
);
  import rfa_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cmd;

  assign cmd = cmd_t'(stat.cmd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd == CMD_INIT) begin
          state_nxt = S_INIT;
        end else if (cmd == CMD_COW && !stat.range_bad && !stat.cnt_one && !stat.cnt_zero) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_POP: begin
        state_nxt = S_OUT;
      end
      S_INIT: begin
        if (stat.sweep_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.res_st = ST_OK;
    ctrl.res_fo = FO_NONE;
    in_ready    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctrl.cnt_we     = 1'b1;
        ctrl.cnt_sel    = CW_SWEEP;
        ctrl.sweep_step = 1'b1;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        ctrl.rd_en = in_valid;
      end
      S_EXEC: begin
        ctrl.res_we = 1'b1;
        unique case (cmd)
          CMD_INIT: begin
            ctrl.res_we = 1'b0;
          end
          CMD_ALLOC: begin
            if (!stat.pc_one) begin
              ctrl.res_st = ST_BADCOUNT;
            end else if (stat.head_null) begin
              ctrl.res_st = ST_EMPTY;
            end else begin
              ctrl.cnt_we  = 1'b1;
              ctrl.cnt_sel = CW_ONE_HEAD;
              ctrl.pop     = 1'b1;
              ctrl.res_fo  = FO_HEAD;
            end
          end
          CMD_FREE: begin
            if (stat.range_bad || stat.cnt_zero) begin
              ctrl.res_st = ST_RANGE;
            end else if (stat.cnt_one) begin
              ctrl.push    = 1'b1;
              ctrl.cnt_we  = 1'b1;
              ctrl.cnt_sel = CW_ZERO;
            end else begin
              ctrl.cnt_we  = 1'b1;
              ctrl.cnt_sel = CW_DEC;
            end
          end
          CMD_ADDREF: begin
            if (stat.range_bad || stat.cnt_max) begin
              ctrl.res_st = ST_RANGE;
            end else begin
              ctrl.cnt_we  = 1'b1;
              ctrl.cnt_sel = CW_INC;
            end
          end
          CMD_COW: begin
            if (stat.range_bad) begin
              ctrl.res_st = ST_RANGE;
            end else if (stat.cnt_one) begin
              ctrl.res_fo = FO_FRAME;
            end else if (stat.cnt_zero) begin
              ctrl.res_st = ST_RANGE;
            end else begin
              // The shared frame loses one owner; the new frame is popped next.
              ctrl.cnt_we  = 1'b1;
              ctrl.cnt_sel = CW_DEC;
              ctrl.res_we  = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        ctrl.res_we = 1'b1;
        if (stat.head_null) begin
          ctrl.res_st = ST_EMPTY;
        end else begin
          ctrl.cnt_we  = 1'b1;
          ctrl.cnt_sel = CW_ONE_HEAD;
          ctrl.pop     = 1'b1;
          ctrl.res_fo  = FO_HEAD;
          ctrl.res_cp  = 1'b1;
        end
      end
      S_INIT: begin
        ctrl.cnt_we     = 1'b1;
        ctrl.cnt_sel    = CW_SWEEP;
        ctrl.sweep_step = 1'b1;
        ctrl.sweep_init = 1'b1;
        if (stat.sweep_last) begin
          ctrl.head_init = 1'b1;
          ctrl.res_we    = 1'b1;
        end
      end
      S_OUT: begin
        ctrl.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/rfa_dpath.sv
// Datapath: count and link memories, free list head, sweep counter and result registers.
module rfa_dpath #(
  parameter int FRAMES   = 1024,
  parameter int REF_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rfa_pkg::rfa_ctrl_t           ctrl,
  output rfa_pkg::rfa_stat_t           stat,
  input  logic [rfa_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rfa_pkg::FRAME_W-1:0]  in_frame,
  input  logic [rfa_pkg::PC_W-1:0]     in_page_count,
  input  logic [rfa_pkg::CFG_W-1:0]    cfg_first,
  input  logic [rfa_pkg::CFG_W-1:0]    cfg_limit,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [rfa_pkg::FO_W-1:0]     out_frame_out,
  output logic [rfa_pkg::ST_W-1:0]     out_status,
  output logic                         out_copy_needed
);
  import rfa_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int XW = (FW > FRAME_W) ? FW : FRAME_W;
  localparam int LW = ((FW + 1) > CFG_W) ? (FW + 1) : CFG_W;
  localparam logic [FW:0]         LINK_NULL = {1'b1, {FW{1'b0}}};
  localparam logic [REF_BITS-1:0] CNT_MAX   = '1;
  localparam logic [REF_BITS-1:0] CNT_ONE   = REF_BITS'(1);

  logic [REF_BITS-1:0] cnt_mem [FRAMES];
  logic [FW:0]         link_mem [FRAMES];

  logic [CMD_W-1:0]    cmd_r;
  logic [FRAME_W-1:0]  frame_r;
  logic                pc_one_r;
  logic [REF_BITS-1:0] cnt_rd_r;
  logic [FW:0]         link_rd_r;
  logic [FW:0]         head_r;
  logic [FW-1:0]       sweep_r;
  logic [FO_W-1:0]     res_fo_r;
  logic [ST_W-1:0]     res_st_r;
  logic                res_cp_r;
  logic                out_valid_r;
  logic [FO_W-1:0]     out_fo_r;
  logic [ST_W-1:0]     out_st_r;
  logic                out_cp_r;

  logic [XW-1:0]       in_frame_x;
  logic [XW-1:0]       frame_x;
  logic [XW-1:0]       head_x;
  logic [FW-1:0]       in_addr;
  logic [FW-1:0]       frame_addr;
  logic [FW-1:0]       head_idx;
  logic                sweep_last;
  logic [LW-1:0]       sweep_x;
  logic [LW-1:0]       first_x;
  logic [LW-1:0]       lim_raw;
  logic [LW-1:0]       lim_x;
  logic                list_nonempty;
  logic                in_region;
  logic                has_next;
  logic [FW:0]         sweep_link;
  logic [REF_BITS-1:0] sweep_cnt;
  logic [FW-1:0]       cnt_wa;
  logic [REF_BITS-1:0] cnt_wd;
  logic                link_we;
  logic [FW-1:0]       link_wa;
  logic [FW:0]         link_wd;
  logic [FO_W-1:0]     res_fo;

  assign in_frame_x = XW'(in_frame);
  assign frame_x    = XW'(frame_r);
  assign in_addr    = in_frame_x[FW-1:0];
  assign frame_addr = frame_x[FW-1:0];
  assign head_idx   = head_r[FW-1:0];
  assign head_x     = XW'(head_idx);
  assign sweep_last = (sweep_r == FW'(FRAMES - 1));

  // Free region for init: the limit is clamped to the table size.
  assign sweep_x       = LW'(sweep_r);
  assign first_x       = LW'(cfg_first);
  assign lim_raw       = LW'(cfg_limit);
  assign lim_x         = (lim_raw > LW'(FRAMES)) ? LW'(FRAMES) : lim_raw;
  assign list_nonempty = (first_x < lim_x);
  assign in_region     = list_nonempty && (sweep_x >= first_x) && (sweep_x < lim_x);
  assign has_next      = ((sweep_x + LW'(1)) < lim_x);
  assign sweep_link    = has_next ? {1'b0, sweep_r + FW'(1)} : LINK_NULL;
  assign sweep_cnt     = (ctrl.sweep_init && !in_region) ? CNT_ONE : '0;

  always_comb begin
    cnt_wa = frame_addr;
    cnt_wd = cnt_rd_r;
    case (ctrl.cnt_sel)
      CW_DEC:      cnt_wd = cnt_rd_r - CNT_ONE;
      CW_INC:      cnt_wd = cnt_rd_r + CNT_ONE;
      CW_ZERO:     cnt_wd = '0;
      CW_ONE_HEAD: begin
        cnt_wa = head_idx;
        cnt_wd = CNT_ONE;
      end
      CW_SWEEP:    begin
        cnt_wa = sweep_r;
        cnt_wd = sweep_cnt;
      end
      default:     cnt_wd = cnt_rd_r;
    endcase
  end

  assign link_we = ctrl.push || (ctrl.sweep_step && ctrl.sweep_init);
  assign link_wa = ctrl.push ? frame_addr : sweep_r;
  assign link_wd = ctrl.push ? head_r : sweep_link;

  always_ff @(posedge clk) begin
    if (ctrl.cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (ctrl.rd_en) cnt_rd_r <= cnt_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (ctrl.rd_en) link_rd_r <= link_mem[head_idx];
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      cmd_r    <= in_cmd;
      frame_r  <= in_frame;
      pc_one_r <= (in_page_count == PC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= LINK_NULL;
      sweep_r <= '0;
    end else begin
      if (ctrl.pop) begin
        head_r <= link_rd_r;
      end else if (ctrl.push) begin
        head_r <= {1'b0, frame_addr};
      end else if (ctrl.head_init) begin
        head_r <= list_nonempty ? {1'b0, first_x[FW-1:0]} : LINK_NULL;
      end
      if (ctrl.sweep_step) sweep_r <= sweep_last ? '0 : sweep_r + FW'(1);
    end
  end

  always_comb begin
    case (ctrl.res_fo)
      FO_FRAME: res_fo = frame_r;
      FO_HEAD:  res_fo = head_x[FO_W-1:0];
      default:  res_fo = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_we) begin
      res_fo_r <= res_fo;
      res_st_r <= ctrl.res_st;
      res_cp_r <= ctrl.res_cp;
    end
    if (ctrl.out_load) begin
      out_fo_r <= res_fo_r;
      out_st_r <= res_st_r;
      out_cp_r <= res_cp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_out   = out_fo_r;
  assign out_status      = out_st_r;
  assign out_copy_needed = out_cp_r;

  always_comb begin
    stat            = '0;
    stat.cmd        = cmd_r;
    stat.range_bad  = (32'(frame_r) >= 32'(FRAMES));
    stat.cnt_zero   = (cnt_rd_r == '0);
    stat.cnt_one    = (cnt_rd_r == CNT_ONE);
    stat.cnt_max    = (cnt_rd_r == CNT_MAX);
    stat.head_null  = head_r[FW];
    stat.pc_one     = pc_one_r;
    stat.sweep_last = sweep_last;
    stat.out_free   = !out_valid_r || out_ready;
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the reference-counted frame allocator top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  localparam int FRAMES      = 1024;
  localparam int REF_BITS    = 8;
  localparam int CNT_MAX     = (1 << REF_BITS) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 135;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame;
    logic [PC_W-1:0]    page_count;
  } frame_cmd_t;

  typedef struct packed {
    logic [FO_W-1:0] frame_out;
    st_t             status;
    logic            copy_needed;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  rfa_in_if  in_ch ();
  rfa_out_if out_ch ();

  refcounted_frame_allocator_top #(
    .FRAMES  (FRAMES),
    .REF_BITS(REF_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow allocator: counts, free-list links and the region registers.
  logic [REF_BITS-1:0] ref_cnt   [FRAMES];
  logic [FRAME_W-1:0]  free_link [FRAMES];
  bit                  link_live [FRAMES];
  logic [FRAME_W-1:0]  list_head;
  bit                  head_live;
  logic [CFG_W-1:0]    region_first;
  logic [CFG_W-1:0]    region_limit;

  frame_cmd_t cmd_q[$];
  grant_t     grant_q[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         in_gap_pct = 0;
  int         out_gap_pct = 0;
  int         in_gap_left = 0;
  int         out_gap_left = 0;
  int         gen_first = 0;
  int         n_taken = 0;

  function automatic bit take_head(output logic [FRAME_W-1:0] got);
    logic [FRAME_W-1:0] f;
    if (!head_live) return 1'b0;
    f = list_head;
    ref_cnt[f] = REF_BITS'(1);
    head_live = link_live[f];
    list_head = free_link[f];
    got = f;
    return 1'b1;
  endfunction

  function automatic grant_t step_allocator(input frame_cmd_t c);
    grant_t             g;
    logic [FRAME_W-1:0] f;
    logic [FRAME_W-1:0] got;
    int                 lim;
    g = '{frame_out: '0, status: ST_OK, copy_needed: 1'b0};
    f = c.frame;
    case (c.cmd)
      CMD_INIT: begin
        lim = (region_limit > FRAMES) ? FRAMES : region_limit;
        for (int i = 0; i < FRAMES; i++) begin
          if (region_first < lim && i >= region_first && i < lim) begin
            ref_cnt[i] = '0;
            link_live[i] = (i + 1 < lim);
            free_link[i] = link_live[i] ? FRAME_W'(i + 1) : '0;
          end else begin
            ref_cnt[i] = REF_BITS'(1);
            link_live[i] = 1'b0;
            free_link[i] = '0;
          end
        end
        head_live = (region_first < lim);
        list_head = head_live ? FRAME_W'(region_first) : '0;
      end
      CMD_ALLOC: begin
        if (c.page_count != 1) g.status = ST_BADCOUNT;
        else if (take_head(got)) g.frame_out = got;
        else g.status = ST_EMPTY;
      end
      CMD_FREE: begin
        if (ref_cnt[f] == 0) begin
          g.status = ST_RANGE;
        end else if (ref_cnt[f] == 1) begin
          free_link[f] = list_head;
          link_live[f] = head_live;
          list_head = f;
          head_live = 1'b1;
          ref_cnt[f] = '0;
        end else begin
          ref_cnt[f] = ref_cnt[f] - REF_BITS'(1);
        end
      end
      CMD_ADDREF: begin
        if (ref_cnt[f] == REF_BITS'(CNT_MAX)) g.status = ST_RANGE;
        else ref_cnt[f] = ref_cnt[f] + REF_BITS'(1);
      end
      CMD_COW: begin
        if (ref_cnt[f] == 1) begin
          g.frame_out = f;
        end else if (ref_cnt[f] == 0) begin
          g.status = ST_RANGE;
        end else begin
          // The dropped reference stays dropped even when no frame is left.
          ref_cnt[f] = ref_cnt[f] - REF_BITS'(1);
          if (take_head(got)) begin
            g.frame_out = got;
            g.copy_needed = 1'b1;
          end else begin
            g.status = ST_EMPTY;
          end
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Command driver; the shadow model advances on every accepted transfer.
  always @(posedge clk) begin : drive
    frame_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        grant_q.push_back(step_allocator({in_ch.cmd, in_ch.frame, in_ch.page_count}));
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered command until it is taken.
      end else if (in_gap_left != 0) begin
        in_gap_left <= in_gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        if ($urandom_range(99, 0) < in_gap_pct) begin
          in_ch.valid <= 1'b0;
          in_gap_left <= $urandom_range(7, 0);
        end else begin
          nxt = cmd_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= nxt.cmd;
          in_ch.frame <= nxt.frame;
          in_ch.page_count <= nxt.page_count;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("result transfer with nothing pending",
                          int'(out_ch.frame_out), 0);
        end else begin
          want = grant_q.pop_front();
          if (out_ch.frame_out !== want.frame_out)
            report_mismatch("frame_out", int'(out_ch.frame_out), int'(want.frame_out));
          if (out_ch.status !== want.status)
            report_mismatch("status", int'(out_ch.status), int'(want.status));
          if (out_ch.copy_needed !== want.copy_needed)
            report_mismatch("copy_needed", int'(out_ch.copy_needed),
                            int'(want.copy_needed));
        end
      end
      if (out_gap_left != 0) begin
        out_gap_left <= out_gap_left - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < out_gap_pct) begin
        out_gap_left <= $urandom_range(7, 0);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] c, input int f, input int pc);
    cmd_q.push_back('{cmd: c, frame: FRAME_W'(f), page_count: PC_W'(pc)});
    if (c == CMD_ALLOC || c == CMD_COW) n_taken++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_ch.valid || grant_q.size() != 0);
  endtask

  task automatic set_region(input int first, input int limit);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_FIRST;
    cfg_wdata <= CFG_W'(first);
    @(posedge clk);
    cfg_idx <= REG_LIMIT;
    cfg_wdata <= CFG_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    region_first = CFG_W'(first);
    region_limit = CFG_W'(limit);
    gen_first = first;
    n_taken = 0;
  endtask

  // Frames just above the region start are the ones the LIFO list hands out first.
  function automatic int pick_frame();
    int base;
    int span;
    if ($urandom_range(9, 0) < 2) return $urandom_range(FRAMES - 1, 0);
    base = (gen_first >= FRAMES) ? $urandom_range(FRAMES - 1, 0) : gen_first;
    span = (n_taken + 2 > 48) ? 48 : n_taken + 2;
    return (base + $urandom_range(span, 0)) % FRAMES;
  endfunction

  initial begin : stimulus
    int r;
    int first;
    int limit;
    int hf;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_FIRST;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INIT;
    in_ch.frame = '0;
    in_ch.page_count = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      ref_cnt[i] = '0;
      free_link[i] = '0;
      link_live[i] = 1'b0;
    end
    list_head = '0;
    head_live = 1'b0;
    region_first = FIRST_RST;
    region_limit = LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    in_gap_pct = 20;
    out_gap_pct = 20;

    // Before any init: the list is empty and every count is zero.
    push_cmd(CMD_ALLOC, 0, 1);
    push_cmd(CMD_FREE, 5, 0);
    push_cmd(CMD_COW, 5, 0);
    push_cmd(CMD_ADDREF, 1023, 0);
    push_cmd(CMD_FREE, 1023, 0);
    push_cmd(CMD_ALLOC, 1023, 1);
    push_cmd(CMD_UNKNOWN_LAST, 1023, 255);
    wait_idle();
    set_region(1020, 1024);
    push_cmd(CMD_INIT, 0, 0);
    push_cmd(CMD_ALLOC, 0, 0);
    push_cmd(CMD_ALLOC, 0, 255);
    push_cmd(CMD_ALLOC, 0, 1);
    push_cmd(CMD_COW, 1020, 0);
    push_cmd(CMD_ADDREF, 1020, 0);
    push_cmd(CMD_COW, 1020, 0);
    // Add_ref on a listed frame leaves it on the list.
    push_cmd(CMD_ADDREF, 1022, 0);
    push_cmd(CMD_ALLOC, 0, 1);
    push_cmd(CMD_ALLOC, 0, 1);
    push_cmd(CMD_ALLOC, 0, 1);
    push_cmd(CMD_ADDREF, 1021, 0);
    push_cmd(CMD_COW, 1021, 0);
    push_cmd(CMD_FREE, 1020, 0);
    push_cmd(CMD_ADDREF, 0, 0);
    push_cmd(CMD_FREE, 0, 0);
    push_cmd(CMD_UNKNOWN_FIRST, 0, 0);
    wait_idle();
    set_region(1024, 1024);
    push_cmd(CMD_INIT, 1023, 255);
    push_cmd(CMD_ALLOC, 0, 1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 6)
        0: begin first = 0; limit = FRAMES; end
        1: begin first = FRAMES; limit = FRAMES; end
        2: begin first = $urandom_range(1000, 0); limit = first + $urandom_range(24, 1); end
        3: begin first = $urandom_range(FRAMES - 1, 1); limit = 0; end
        4: begin first = 0; limit = $urandom_range(16, 1); end
        default: begin first = $urandom_range(FRAMES - 1, 1000); limit = FRAMES; end
      endcase
      set_region(first, limit);
      if (ph == 6 || ph == PHASES - 1) begin
        in_gap_pct = 0;
        out_gap_pct = 0;
      end else begin
        in_gap_pct = $urandom_range(40, 5);
        out_gap_pct = $urandom_range(40, 5);
      end
      push_cmd(CMD_INIT, $urandom_range(FRAMES - 1, 0), $urandom_range(255, 0));
      if (ph == 1) begin
        // Every frame starts at one reference here, so this climbs into overflow.
        hf = $urandom_range(FRAMES - 1, 0);
        repeat (CNT_MAX + 3) push_cmd(CMD_ADDREF, hf, $urandom_range(255, 0));
        push_cmd(CMD_COW, hf, 0);
        push_cmd(CMD_FREE, hf, 0);
      end
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(99, 0);
        if (r < 2)
          push_cmd(CMD_INIT, $urandom_range(FRAMES - 1, 0), $urandom_range(255, 0));
        else if (r < 32)
          push_cmd(CMD_ALLOC, $urandom_range(FRAMES - 1, 0),
                   ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0) : 1);
        else if (r < 52)
          push_cmd(CMD_FREE, pick_frame(), $urandom_range(255, 0));
        else if (r < 66)
          push_cmd(CMD_ADDREF, pick_frame(), $urandom_range(255, 0));
        else if (r < 86)
          push_cmd(CMD_COW, pick_frame(), $urandom_range(255, 0));
        else if (r < 90)
          push_cmd(CMD_W'($urandom_range(CMD_UNKNOWN_LAST, CMD_UNKNOWN_FIRST)),
                   $urandom_range(FRAMES - 1, 0), $urandom_range(255, 0));
        else
          push_cmd(CMD_W'($urandom_range(CMD_UNKNOWN_LAST, CMD_INIT)),
                   $urandom_range(FRAMES - 1, 0), $urandom_range(255, 0));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
